// ----- sv/pid_step_slew_limited_macros.svh -----
// Assertion macros for the slew-limited PID step block.
`ifndef PID_STEP_SLEW_LIMITED_MACROS_SVH
`define PID_STEP_SLEW_LIMITED_MACROS_SVH
`ifndef SYNTHESIS
`define PSL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define PSL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define PSL_ASSERT(label, prop, msg)
`define PSL_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- sv/pidsl_pkg.sv -----
// Types, widths, register indexes and saturation helper of the slew-limited PID step.
package pidsl_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int ERR_W      = 32;
    localparam int GAIN_W     = 32;
    localparam int LIM_W      = 31;
    localparam int FRAC_W     = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DIFF_W  = ERR_W + 1;
    localparam int PROD_W  = GAIN_W + ERR_W;
    localparam int PRODD_W = GAIN_W + DIFF_W;
    localparam int D500_W  = PRODD_W + 9;
    localparam int TERM_W  = PROD_W - FRAC_W + 1;
    localparam int DTERM_W = D500_W - FRAC_W;
    localparam int RAW_W   = DTERM_W + 2;
    localparam int SLEW_W  = DATA_WIDTH + 1;

    localparam logic [LIM_W-1:0] SLEW_THR_RST  = LIM_W'(3277);
    localparam logic [LIM_W-1:0] SLEW_STEP_RST = LIM_W'(6554);

    localparam logic signed [RAW_W-1:0] RAW_HI =
        $signed({{(RAW_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}});
    localparam logic signed [RAW_W-1:0] RAW_LO = ~RAW_HI;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_KP,
        REG_KI,
        REG_KD,
        REG_DONE_THR,
        REG_INT_LIM,
        REG_ACC_LIM,
        REG_SLEW_THR,
        REG_SLEW_STEP
    } cfg_reg_t;

    typedef logic signed [ERR_W-1:0]      err_t;
    typedef logic signed [GAIN_W-1:0]     gain_t;
    typedef logic signed [DATA_WIDTH-1:0] drive_t;

    function automatic drive_t sat_drive(input logic signed [RAW_W-1:0] v);
        drive_t r;
        if (v > RAW_HI) begin
            r = RAW_HI[DATA_WIDTH-1:0];
        end else if (v < RAW_LO) begin
            r = RAW_LO[DATA_WIDTH-1:0];
        end else begin
            r = v[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/pid_step_slew_limited.sv -----
// Top level: pipelined PID step with integrator clamp and slew limit.
// One error sample per accepted request, one result per sample, in order. The pipeline
// takes a new sample every cycle while the output is not stalled; a result passes through
// the integrator update, three products, two sum stages and the slew stage into the output
// register. The integrator and error history close their loop in the first stage and the
// last drive in the slew stage, so back-to-back samples run at full rate. The user must
// write gains and limits through the cfg port only while the pipeline is empty; the block
// itself does not enforce it. No clearing pass after reset.
`include "pid_step_slew_limited_macros.svh"

module pid_step_slew_limited (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pidsl_pkg::ERR_W-1:0]          s_tdata,    // [31:0] error
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pidsl_pkg::DATA_WIDTH-1:0]     m_tdata,    // [31:0] drive
    output logic                                 m_tuser,    // [0] done_res
    input  logic                                 cfg_wr_en,
    input  logic [pidsl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pidsl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import pidsl_pkg::*;

    gain_t              kp_reg, ki_reg, kd_reg;
    err_t               acc_lim_reg;
    logic [LIM_W-1:0]   done_thr_reg, int_lim_reg, slew_thr_reg, slew_step_reg;

    err_t               int_reg, h0_reg, h1_reg, h2_reg;
    drive_t             last_drive_reg;

    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, out_valid_reg;
    err_t               e1_reg, e2_reg, int2_reg;
    logic signed [DIFF_W-1:0]  d2_reg;
    logic signed [PROD_W-1:0]  pp3_reg, pi3_reg;
    logic signed [PRODD_W-1:0] pd3_reg;
    logic signed [DTERM_W-1:0] dterm4_reg;
    logic signed [TERM_W-1:0]  pi4_reg;
    drive_t             raw5_reg, drive_reg;
    logic               done2_reg, done3_reg, done4_reg, done5_reg, done_out_reg;

    logic               rdy1, rdy2, rdy3, rdy4, rdy5, out_rdy;
    logic               adv1, adv2, adv3, adv4, adv5;

    logic [ERR_W-1:0]          mag1;
    logic                      done1, upd1;
    logic signed [ERR_W:0]     acc1, lim_pos, lim_neg, clamp1;
    err_t                      int_next, h0_new, h2_new;
    logic signed [DIFF_W-1:0]  d1;

    logic signed [PROD_W-1:0]  pp_next, pi_next;
    logic signed [PRODD_W-1:0] pd_next;
    logic signed [D500_W-1:0]  pd_ext, pd500;
    logic signed [TERM_W-1:0]  pi_sum;
    logic signed [RAW_W-1:0]   raw_sum;

    logic signed [SLEW_W-1:0]  slew_diff, slew_mag, slew_up, slew_dn, step_ext;
    logic                      slew_hit;
    drive_t                    drive_next;

    // advance chain, back to front
    assign out_rdy  = !out_valid_reg || m_tready;
    assign rdy5     = !v5_reg || out_rdy;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign adv1     = v1_reg && rdy2;
    assign adv2     = v2_reg && rdy3;
    assign adv3     = v3_reg && rdy4;
    assign adv4     = v4_reg && rdy5;
    assign adv5     = v5_reg && out_rdy;

    assign s_tready = rdy1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = drive_reg;
    assign m_tuser  = done_out_reg;

    // stage 1: done test, integrator and history update
    always_comb begin
        mag1    = e1_reg[ERR_W-1] ? (~e1_reg + 1'b1) : e1_reg;
        done1   = mag1 < {1'b0, done_thr_reg};
        upd1    = !done1 && (e1_reg < acc_lim_reg);
        acc1    = {int_reg[ERR_W-1], int_reg} + {e1_reg[ERR_W-1], e1_reg};
        lim_pos = $signed({2'b00, int_lim_reg});
        lim_neg = -lim_pos;
        if (acc1 > lim_pos) begin
            clamp1 = lim_pos;
        end else if (acc1 < lim_neg) begin
            clamp1 = lim_neg;
        end else begin
            clamp1 = acc1;
        end
        int_next = upd1 ? clamp1[ERR_W-1:0] : int_reg;
        h0_new   = upd1 ? e1_reg : h0_reg;
        h2_new   = upd1 ? h1_reg : h2_reg;
        d1       = DIFF_W'(h0_new) - DIFF_W'(h2_new);
    end

    // stage 2: products
    always_comb begin
        pp_next = e2_reg * kp_reg;
        pi_next = int2_reg * ki_reg;
        pd_next = d2_reg * kd_reg;
    end

    // stage 3: derivative times 500, floor shifts
    always_comb begin
        pd_ext = D500_W'(pd3_reg);
        pd500  = (pd_ext <<< 9) - (pd_ext <<< 3) - (pd_ext <<< 2);
        pi_sum = TERM_W'($signed(pp3_reg[PROD_W-1:FRAC_W]))
               + TERM_W'($signed(pi3_reg[PROD_W-1:FRAC_W]));
    end

    // stage 4: final sum
    assign raw_sum = RAW_W'(dterm4_reg) + RAW_W'(pi4_reg);

    // stage 5: slew limit against the last drive
    always_comb begin
        step_ext  = $signed({2'b00, slew_step_reg});
        slew_diff = SLEW_W'(last_drive_reg) - SLEW_W'(raw5_reg);
        slew_mag  = slew_diff[SLEW_W-1] ? -slew_diff : slew_diff;
        slew_hit  = slew_mag > $signed({2'b00, slew_thr_reg});
        slew_up   = SLEW_W'(last_drive_reg) + step_ext;
        slew_dn   = SLEW_W'(last_drive_reg) - step_ext;
        if (!slew_hit) begin
            drive_next = raw5_reg;
        end else if (slew_diff > 0) begin
            drive_next = sat_drive(RAW_W'(slew_dn));
        end else begin
            drive_next = sat_drive(RAW_W'(slew_up));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg         <= '0;
            ki_reg         <= '0;
            kd_reg         <= '0;
            done_thr_reg   <= '0;
            int_lim_reg    <= '0;
            acc_lim_reg    <= '0;
            slew_thr_reg   <= SLEW_THR_RST;
            slew_step_reg  <= SLEW_STEP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_KP:        kp_reg        <= cfg_wdata;
                REG_KI:        ki_reg        <= cfg_wdata;
                REG_KD:        kd_reg        <= cfg_wdata;
                REG_DONE_THR:  done_thr_reg  <= cfg_wdata[LIM_W-1:0];
                REG_INT_LIM:   int_lim_reg   <= cfg_wdata[LIM_W-1:0];
                REG_ACC_LIM:   acc_lim_reg   <= cfg_wdata;
                REG_SLEW_THR:  slew_thr_reg  <= cfg_wdata[LIM_W-1:0];
                REG_SLEW_STEP: slew_step_reg <= cfg_wdata[LIM_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            v5_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            int_reg        <= '0;
            h0_reg         <= '0;
            h1_reg         <= '0;
            h2_reg         <= '0;
            last_drive_reg <= '0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
            if (rdy5) begin
                v5_reg <= v4_reg;
            end
            if (out_rdy) begin
                out_valid_reg <= v5_reg;
            end
            if (adv1) begin
                int_reg <= int_next;
                if (upd1) begin
                    h0_reg <= e1_reg;
                    h1_reg <= h0_reg;
                    h2_reg <= h1_reg;
                end
            end
            if (adv5) begin
                last_drive_reg <= drive_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && rdy1) begin
            e1_reg <= s_tdata;
        end
        if (adv1) begin
            e2_reg    <= e1_reg;
            int2_reg  <= int_next;
            d2_reg    <= d1;
            done2_reg <= done1;
        end
        if (adv2) begin
            pp3_reg   <= pp_next;
            pi3_reg   <= pi_next;
            pd3_reg   <= pd_next;
            done3_reg <= done2_reg;
        end
        if (adv3) begin
            dterm4_reg <= pd500[D500_W-1:FRAC_W];
            pi4_reg    <= pi_sum;
            done4_reg  <= done3_reg;
        end
        if (adv4) begin
            raw5_reg  <= sat_drive(raw_sum);
            done5_reg <= done4_reg;
        end
        if (adv5) begin
            drive_reg    <= drive_next;
            done_out_reg <= done5_reg;
        end
    end

    `PSL_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_tvalid, "output valid after reset")
    `PSL_ASSERT(a_stall_only_when_full,
        !s_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && out_valid_reg),
        "input stalled with a bubble in the pipeline")
    `PSL_ASSERT(a_int_clamped,
        (adv1 && upd1) |-> ((acc1 > lim_pos) || (acc1 < lim_neg)
            || (int_next == acc1[ERR_W-1:0]))
            && ($signed({int_next[ERR_W-1], int_next}) <= lim_pos)
            && ($signed({int_next[ERR_W-1], int_next}) >= lim_neg),
        "integrator outside its clamp")
    `PSL_ASSERT(a_done_holds_int, (adv1 && done1) |=> $stable(int_reg),
        "integrator moved on a done request")
    `PSL_ASSERT(a_last_drive_tracks, adv5 |=> (last_drive_reg == drive_reg),
        "last drive differs from delivered drive")

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the slew-limited PID step: directed and random errors against a predictor.
module testbench;
    import pidsl_pkg::*;

    typedef struct packed {
        drive_t drive;
        logic   done;
    } pid_result_t;

    localparam int QUIET_LIMIT = 4000;
    localparam int RAND_PHASES = 6;
    localparam int RAND_ITEMS  = 64;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [ERR_W-1:0]      s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_WIDTH-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // controller settings and state as the block should hold them
    longint kp_q = 0, ki_q = 0, kd_q = 0, acc_lim_q = 0;
    longint done_thr_q = 0, int_lim_q = 0, slew_thr_q = 3277, slew_step_q = 6554;
    longint integ_q = 0, last_drive_q = 0;
    longint err_hist_q [3] = '{0, 0, 0};

    err_t        error_queue[$];
    pid_result_t expected_results[$];

    bit idle_on = 1'b1;
    bit s_taken = 1'b0;
    int send_gap = 0;
    int ready_gap = 0;
    int hold_reqs = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int mismatch_cnt = 0;
    int sent_cnt = 0;
    int checked_cnt = 0;
    int done_cnt = 0;
    int settings_cnt = 0;

    pid_step_slew_limited i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint sat_q31(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // floor(g * x / 2^16) from the exact product
    function automatic longint gain_mul(input longint g, input longint x);
        logic signed [127:0] gw;
        logic signed [127:0] xw;
        logic signed [127:0] p;
        gw = g;
        xw = x;
        p = gw * xw;
        p = p >>> FRAC_W;
        return p[63:0];
    endfunction

    function automatic pid_result_t pid_step_predict(input err_t err_in);
        pid_result_t res;
        longint e, mag, acc, raw, delta, nxt;
        bit done;
        e = err_in;
        mag = (e < 0) ? -e : e;
        done = mag < done_thr_q;
        if (!done && e < acc_lim_q) begin
            acc = integ_q + e;
            if (acc > int_lim_q) begin
                acc = int_lim_q;
            end else if (acc < -int_lim_q) begin
                acc = -int_lim_q;
            end
            integ_q = acc;
            err_hist_q[2] = err_hist_q[1];
            err_hist_q[1] = err_hist_q[0];
            err_hist_q[0] = e;
        end
        raw = sat_q31(gain_mul(kp_q, e) + gain_mul(ki_q, integ_q)
                      + gain_mul(kd_q, (err_hist_q[0] - err_hist_q[2]) * 500));
        delta = last_drive_q - raw;
        if (delta < 0) begin
            delta = -delta;
        end
        nxt = raw;
        if (delta > slew_thr_q) begin
            nxt = (last_drive_q > raw) ? sat_q31(last_drive_q - slew_step_q)
                                       : sat_q31(last_drive_q + slew_step_q);
        end
        last_drive_q = nxt;
        res.drive = nxt[DATA_WIDTH-1:0];
        res.done = done;
        return res;
    endfunction

    task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        case (r)
            REG_KP:        kp_q = longint'($signed(v));
            REG_KI:        ki_q = longint'($signed(v));
            REG_KD:        kd_q = longint'($signed(v));
            REG_DONE_THR:  done_thr_q = v[LIM_W-1:0];
            REG_INT_LIM:   int_lim_q = v[LIM_W-1:0];
            REG_ACC_LIM:   acc_lim_q = longint'($signed(v));
            REG_SLEW_THR:  slew_thr_q = v[LIM_W-1:0];
            REG_SLEW_STEP: slew_step_q = v[LIM_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] kp, input logic [31:0] ki,
                             input logic [31:0] kd, input logic [31:0] done_thr,
                             input logic [31:0] int_lim, input logic [31:0] acc_lim,
                             input logic [31:0] slew_thr, input logic [31:0] slew_step);
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_KD, kd);
        write_reg(REG_DONE_THR, done_thr);
        write_reg(REG_INT_LIM, int_lim);
        write_reg(REG_ACC_LIM, acc_lim);
        write_reg(REG_SLEW_THR, slew_thr);
        write_reg(REG_SLEW_STEP, slew_step);
        settings_cnt++;
    endtask

    task automatic wait_drained();
        while (error_queue.size() != 0 || s_tvalid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_gain();
        logic signed [31:0] g;
        case ($urandom_range(0, 4))
            0: g = $urandom;
            1: g = $urandom_range(0, 32'h0000_ffff);
            default: g = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return $urandom & 32'h7fff_ffff;
            2: return 32'h7fff_ffff;
            default: return $urandom_range(0, 32'h0003_0000);
        endcase
    endfunction

    function automatic err_t pick_error();
        err_t e;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: e = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            4, 5: e = $urandom;
            6: begin
                case ($urandom_range(0, 3))
                    0: e = 32'h7fff_ffff;
                    1: e = 32'h8000_0000;
                    2: e = 32'h8000_0001;
                    default: e = '0;
                endcase
            end
            7: begin
                e = err_t'(done_thr_q) + ($signed($urandom_range(0, 4)) - 2);
                if ($urandom_range(0, 1)) begin
                    e = -e;
                end
            end
            8: e = err_t'(acc_lim_q) + ($signed($urandom_range(0, 4)) - 2);
            default: e = $signed($urandom_range(0, 16)) - 8;
        endcase
        return e;
    endfunction

    // driver: offer queued errors, hold each until taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (error_queue.size() != 0) begin
                s_tdata  <= error_queue.pop_front();
                s_tvalid <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 4);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        s_taken = 1'b0;
    end

    // receiver: random short stalls, plus a long hold on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_served != hold_reqs) begin
            hold_served++;
            hold_left = 59;
            m_tready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0) begin
                ready_gap = $urandom_range(1, 4);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            expected_results.push_back(pid_step_predict(s_tdata));
            s_taken = 1'b1;
            sent_cnt++;
        end
    end

    always @(posedge aclk) begin
        pid_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            checked_cnt++;
            if (m_tuser) begin
                done_cnt++;
            end
            if (expected_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("unexpected result: drive %h done %b", m_tdata, m_tuser);
                end
            end else begin
                want = expected_results.pop_front();
                if (m_tdata !== want.drive || m_tuser !== want.done) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("result %0d: drive exp %h got %h, done exp %b got %b",
                                 checked_cnt, want.drive, m_tdata, want.done, m_tuser);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // reset settings: zero gains, zero done threshold and limits, default slew threshold and step
        error_queue = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001,
                        32'hffff_ffff};
        wait_drained();

        // done boundary, accumulate boundary, integrator clamp both ways, slew both ways
        write_all(32'h0001_0000, 32'h0000_8000, 32'h0000_0290, 32'h0000_1000,
                  32'h0004_0000, 32'h0002_0000, 32'h0000_8000, 32'h0000_4000);
        error_queue = '{32'h0000_0fff, 32'h0000_1000, -32'sh0000_0fff, -32'sh0000_1000,
                        32'h0001_ffff, 32'h0001_ffff, 32'h0001_ffff, 32'h0002_0000,
                        32'h7fff_ffff, -32'sh0003_0000, -32'sh0003_0000, -32'sh0003_0000,
                        32'h8000_0000};
        wait_drained();

        // extreme gains and limits: saturated drive, full-range slew
        write_all(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        error_queue = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000};
        wait_drained();

        // lowered integrator limit, zero slew threshold and step
        write_all(32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h7fff_ffff,
                  32'h0000_0100, 32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000);
        error_queue = '{32'h0000_0005, 32'h8000_0000, 32'h0000_0003};
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            write_all(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit(),
                      ($urandom_range(0, 2) == 0) ? $urandom
                          : $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000,
                      pick_limit(), pick_limit());
            idle_on = (p < RAND_PHASES - 1);
            if (p == 2) begin
                hold_reqs++;
            end
            for (int i = 0; i < RAND_ITEMS; i++) begin
                error_queue.push_back(pick_error());
            end
            wait_drained();
        end

        $display("%0d errors sent over %0d register settings, %0d results checked (%0d done)",
                 sent_cnt, settings_cnt, checked_cnt, done_cnt);
        $display("covered saturation, integrator clamp, slew limiting and output back-pressure");
        if (mismatch_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
